// ===== design/tccw_pkg.sv =====
// types and constants shared by the text console character writer
`timescale 1ns / 1ps
package tccw_pkg;

  localparam int OPCODE_W   = 1;
  localparam int CHAR_W     = 8;
  localparam int ADDR_W     = 11;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int LOC_W      = 11;
  localparam int CELL_W     = 16;
  localparam int ATTR_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [CHAR_W-1:0]     char_t;
  typedef logic [ATTR_W-1:0]     attr_t;
  typedef logic [CELL_W-1:0]     cell_t;

  // register indexes
  localparam cfg_idx_t CFG_TEXT_ATTR  = 1'd0;
  localparam cfg_idx_t CFG_BLANK_ATTR = 1'd1;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_PUT  = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_READ = 1'b1;

  localparam char_t NEWLINE_CODE    = 8'h0a;
  localparam char_t SPACE_CODE      = 8'h20;
  localparam cell_t RESET_CELL      = 16'h0720;
  localparam attr_t TEXT_ATTR_RST   = 8'h07;
  localparam attr_t BLANK_ATTR_RST  = 8'h0f;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [CHAR_W-1:0]   char_code;
    logic [ADDR_W-1:0]   cell_address;
  } req_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [LOC_W-1:0]  cursor_location;
    logic              scrolled;
    logic [CELL_W-1:0] cell_value;
  } rsp_t;

endpackage

// ===== design/tccw_if.sv =====
// request and response channel interfaces of the text console writer
`timescale 1ns / 1ps
interface tccw_req_if;
  import tccw_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tccw_rsp_if;
  import tccw_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/text_console_char_writer_core.sv =====
// text console character writer: screen memory, cursor and scroll sequencer
// results: a put that does not scroll loads the result register on acceptance, a read
// passes the registered memory read then the result register, a scrolling put runs a
// copy sweep then bottom-row fill via the memory write port, one cell a cycle
// throughput: one item at a time; the next is taken once the result register frees
// reset: the screen is cleared to 0x0720 by a pass over every cell, items wait
`timescale 1ns / 1ps
module text_console_char_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  tccw_pkg::cfg_idx_t  cfg_idx_i,
  input  tccw_pkg::cfg_data_t cfg_data_i,
  tccw_req_if.sink            req_i,
  tccw_rsp_if.source          rsp_o
);
  import tccw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam int CW    = $clog2(COLUMNS);
  localparam int EW    = ((AW > ADDR_W) ? AW : ADDR_W) + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_RDW   = 3'd2;
  localparam logic [2:0] ST_COPY  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_FILL  = 3'd5;

  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] FILL_START = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] LAST_ROW_LOC = AW'((ROWS - 1) * COLUMNS);

  cell_t         mem [CELLS];
  cell_t         rd_q;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] cp_addr_q;
  logic          cp_pend_q;
  logic          rd_ok_q;

  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [AW-1:0] loc_q, loc_d;
  attr_t         text_attr_q, blank_attr_q;

  logic          rsp_vld_q;
  rsp_t          rsp_q;

  logic          accept;
  logic          is_put, is_nl, do_nl, do_scroll;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  cell_t         wdata;
  logic          rd_ok;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic [AW:0]   nl_loc;
  logic          ld;
  logic          ld_scr;
  cell_t         ld_val;

  assign req_i.ready   = (state_q == ST_IDLE) && (!rsp_vld_q || rsp_o.ready);
  assign accept        = req_i.valid && req_i.ready;
  assign rsp_o.valid   = rsp_vld_q;
  assign rsp_o.payload = rsp_q;

  assign is_put = (req_i.payload.opcode == OP_PUT);
  assign is_nl  = (req_i.payload.char_code == NEWLINE_CODE);
  assign rd_ok  = EW'(req_i.payload.cell_address) < EW'(CELLS);

  assign col_inc = (CW + 1)'(col_q) + (CW + 1)'(1);
  assign row_inc = (RW + 1)'(row_q) + (RW + 1)'(1);
  assign nl_loc  = (AW + 1)'(loc_q) - (AW + 1)'(col_q) + (AW + 1)'(COLUMNS);

  // cursor update for a put
  always_comb begin
    row_d     = row_q;
    col_d     = col_q;
    loc_d     = loc_q;
    do_nl     = 1'b0;
    do_scroll = 1'b0;
    if (accept && is_put) begin
      if (is_nl) begin
        do_nl = 1'b1;
      end else if (col_inc == (CW + 1)'(COLUMNS)) begin
        do_nl = 1'b1;
      end else begin
        col_d = col_inc[CW-1:0];
        loc_d = loc_q + AW'(1);
      end
      if (do_nl) begin
        col_d = '0;
        if (row_inc == (RW + 1)'(ROWS)) begin
          do_scroll = 1'b1;
          row_d     = RW'(ROWS - 1);
          loc_d     = LAST_ROW_LOC;
        end else begin
          row_d = row_inc[RW-1:0];
          loc_d = nl_loc[AW-1:0];
        end
      end
    end
  end

  // screen memory port control
  always_comb begin
    we    = 1'b0;
    waddr = loc_q;
    wdata = {text_attr_q, req_i.payload.char_code};
    raddr = AW'(req_i.payload.cell_address);
    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = RESET_CELL;
      end
      ST_IDLE: begin
        we = accept && is_put && !is_nl;
      end
      ST_COPY: begin
        raddr = cnt_q;
        we    = cp_pend_q;
        waddr = cp_addr_q;
        wdata = rd_q;
      end
      ST_DRAIN: begin
        we    = 1'b1;
        waddr = cp_addr_q;
        wdata = rd_q;
      end
      ST_FILL: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = {blank_attr_q, SPACE_CODE};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ld      = 1'b0;
    ld_scr  = 1'b0;
    ld_val  = '0;
    case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == LAST_CELL) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (!is_put) begin
            state_d = ST_RDW;
          end else if (do_scroll) begin
            state_d = ST_COPY;
            cnt_d   = AW'(COLUMNS);
          end else begin
            ld = 1'b1;
          end
        end
      end
      ST_RDW: begin
        ld      = 1'b1;
        ld_val  = rd_ok_q ? rd_q : '0;
        state_d = ST_IDLE;
      end
      ST_COPY: begin
        if (cnt_q == LAST_CELL) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        cnt_d   = FILL_START;
        state_d = ST_FILL;
      end
      ST_FILL: begin
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == LAST_CELL) begin
          ld      = 1'b1;
          ld_scr  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cnt_q        <= '0;
      cp_pend_q    <= 1'b0;
      row_q        <= '0;
      col_q        <= '0;
      loc_q        <= '0;
      text_attr_q  <= TEXT_ATTR_RST;
      blank_attr_q <= BLANK_ATTR_RST;
      rsp_vld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cp_pend_q <= (state_q == ST_COPY);
      row_q     <= row_d;
      col_q     <= col_d;
      loc_q     <= loc_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TEXT_ATTR:  text_attr_q  <= cfg_data_i;
          CFG_BLANK_ATTR: blank_attr_q <= cfg_data_i;
          default: begin
            text_attr_q <= text_attr_q;
          end
        endcase
      end
      if (ld) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  // payload and copy address registers
  always_ff @(posedge clk_i) begin
    // copy destination trails the source by one row
    cp_addr_q <= cnt_q - AW'(COLUMNS);
    if (accept) begin
      rd_ok_q <= rd_ok;
    end
    if (ld) begin
      rsp_q.cursor_row      <= ROW_W'(row_d);
      rsp_q.cursor_col      <= COL_W'(col_d);
      rsp_q.cursor_location <= LOC_W'(loc_d);
      rsp_q.scrolled        <= ld_scr;
      rsp_q.cell_value      <= ld_val;
    end
  end

endmodule
